// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define SHK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// same-cycle implication
`define SHK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `SHK_ASSERT(label, clk, rst_n, (ante) |-> (cons))

// next-cycle implication
`define SHK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `SHK_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== hdl/shk_pkg.sv =====
// ----------------------------------------------------------------------------
// shk_pkg
// Types, constants and microcode table of the keyed SipHash engine.
// ----------------------------------------------------------------------------
package shk_pkg;

  localparam int unsigned PcW = 3;

  localparam logic [63:0] InitA = 64'h736f6d6570736575;
  localparam logic [63:0] InitB = 64'h646f72616e646f6d;
  localparam logic [63:0] InitC = 64'h6c7967656e657261;
  localparam logic [63:0] InitD = 64'h7465646279746573;
  localparam logic [63:0] FinalMark = 64'h00000000000000ff;

  localparam int unsigned RotB1 = 13;
  localparam int unsigned RotD1 = 16;
  localparam int unsigned RotD2 = 21;
  localparam int unsigned RotB2 = 17;
  localparam int unsigned RotHalf = 32;

  localparam logic [3:0] ByteCntFull = 4'd8;

  localparam logic [7:0] CFG_KEY_LOW  = 8'd0;
  localparam logic [7:0] CFG_KEY_HIGH = 8'd1;
  localparam logic [7:0] CFG_C_ROUNDS = 8'd2;
  localparam logic [7:0] CFG_D_ROUNDS = 8'd3;

  localparam logic [3:0] CRoundsReset = 4'd2;
  localparam logic [3:0] DRoundsReset = 4'd4;

  localparam logic [PcW-1:0] STEP_WAIT   = 3'd0;
  localparam logic [PcW-1:0] STEP_ABSORB = 3'd1;
  localparam logic [PcW-1:0] STEP_CROUND = 3'd2;
  localparam logic [PcW-1:0] STEP_XOR_A  = 3'd3;
  localparam logic [PcW-1:0] STEP_CHECK  = 3'd4;
  localparam logic [PcW-1:0] STEP_FINAL  = 3'd5;
  localparam logic [PcW-1:0] STEP_DROUND = 3'd6;
  localparam logic [PcW-1:0] STEP_EMIT   = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LOAD   = 3'd1,
    OP_ABSORB = 3'd2,
    OP_ROUND  = 3'd3,
    OP_XOR_A  = 3'd4,
    OP_FINAL  = 3'd5,
    OP_EMIT   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_NO_ACCEPT = 3'd1,
    C_RCNT_MORE = 3'd2,
    C_NOT_LAST  = 3'd3,
    C_NOT_FIN   = 3'd4,
    C_OUT_BUSY  = 3'd5
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic [PcW-1:0] next;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic en;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic fin;
    logic rcnt_more;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned amt);
    return (x << amt) | (x >> (64 - amt));
  endfunction

  // taken cond -> target, else next
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: STEP_WAIT, next: STEP_WAIT};
    case (pc)
      STEP_WAIT:   w = '{op: OP_LOAD, cond: C_NO_ACCEPT, target: STEP_WAIT,
                         next: STEP_ABSORB};
      STEP_ABSORB: w = '{op: OP_ABSORB, cond: C_NEVER, target: STEP_CROUND,
                         next: STEP_CROUND};
      STEP_CROUND: w = '{op: OP_ROUND, cond: C_RCNT_MORE, target: STEP_CROUND,
                         next: STEP_XOR_A};
      STEP_XOR_A:  w = '{op: OP_XOR_A, cond: C_NOT_LAST, target: STEP_WAIT,
                         next: STEP_CHECK};
      STEP_CHECK:  w = '{op: OP_NOP, cond: C_NOT_FIN, target: STEP_ABSORB,
                         next: STEP_FINAL};
      STEP_FINAL:  w = '{op: OP_FINAL, cond: C_NEVER, target: STEP_DROUND,
                         next: STEP_DROUND};
      STEP_DROUND: w = '{op: OP_ROUND, cond: C_RCNT_MORE, target: STEP_DROUND,
                         next: STEP_EMIT};
      STEP_EMIT:   w = '{op: OP_EMIT, cond: C_OUT_BUSY, target: STEP_EMIT,
                         next: STEP_WAIT};
      default:     w = '{op: OP_NOP, cond: C_NEVER, target: STEP_WAIT,
                         next: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/shk_round.sv =====
// ----------------------------------------------------------------------------
// shk_round
// One SipRound over the four 64-bit lanes.
// ----------------------------------------------------------------------------
module shk_round (
  input  shk_pkg::lanes_t lanes_i,
  output shk_pkg::lanes_t lanes_o
);

  logic [63:0] a1, a2, a3;
  logic [63:0] b1, b2;
  logic [63:0] c1, c2;
  logic [63:0] d1, d2;

  always_comb begin
    a1 = lanes_i.a + lanes_i.b;
    b1 = shk_pkg::rotl(lanes_i.b, shk_pkg::RotB1) ^ a1;
    a2 = shk_pkg::rotl(a1, shk_pkg::RotHalf);
    c1 = lanes_i.c + lanes_i.d;
    d1 = shk_pkg::rotl(lanes_i.d, shk_pkg::RotD1) ^ c1;
    a3 = a2 + d1;
    d2 = shk_pkg::rotl(d1, shk_pkg::RotD2) ^ a3;
    c2 = c1 + b1;
    b2 = shk_pkg::rotl(b1, shk_pkg::RotB2) ^ c2;
    lanes_o.a = a3;
    lanes_o.b = b2;
    lanes_o.c = shk_pkg::rotl(c2, shk_pkg::RotHalf);
    lanes_o.d = d2;
  end

endmodule

// ===== hdl/shk_datapath.sv =====
// ----------------------------------------------------------------------------
// shk_datapath
// Lanes, key and round registers, block builder and output register.
// ----------------------------------------------------------------------------
module shk_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  shk_pkg::ctrl_t   ctrl_i,
  input  shk_pkg::cfg_wr_t cfg_i,
  input  logic [63:0]      message_word_i,
  input  logic [3:0]       byte_count_i,
  input  logic             last_word_i,
  input  logic             out_stall_i,
  output shk_pkg::stat_t   stat_o,
  output logic             out_valid_o,
  output logic [63:0]      hash_value_o
);

  logic [63:0] key_lo_q, key_lo_d, key_hi_q, key_hi_d;
  logic [3:0]  crounds_q, crounds_d, frounds_q, frounds_d;
  logic        in_msg_q, in_msg_d;
  logic [7:0]  len_q, len_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic        fin_q, fin_d;
  logic [3:0]  rcnt_q, rcnt_d;
  logic        out_valid_q, out_valid_d;

  shk_pkg::lanes_t lanes_q, lanes_d, lanes_rnd;
  logic [63:0] word_q, word_d, blk_q, blk_d, hash_q, hash_d;

  logic        full;
  logic [7:0]  len_fin;
  logic [63:0] masked, absorb_blk;

  shk_round u_round (
    .lanes_i(lanes_q),
    .lanes_o(lanes_rnd)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < cnt_q) ? word_q[8*i +: 8] : 8'h00;
    end
    full       = !last_q || (cnt_q == shk_pkg::ByteCntFull);
    len_fin    = len_q + {4'b0000, cnt_q};
    absorb_blk = full ? word_q : (masked | {len_fin, 56'h0});
  end

  always_comb begin
    key_lo_d    = key_lo_q;
    key_hi_d    = key_hi_q;
    crounds_d   = crounds_q;
    frounds_d   = frounds_q;
    in_msg_d    = in_msg_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    fin_d       = fin_q;
    rcnt_d      = rcnt_q;
    out_valid_d = out_valid_q;
    lanes_d     = lanes_q;
    word_d      = word_q;
    blk_d       = blk_q;
    hash_d      = hash_q;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        shk_pkg::CFG_KEY_LOW:  key_lo_d = cfg_i.data;
        shk_pkg::CFG_KEY_HIGH: key_hi_d = cfg_i.data;
        shk_pkg::CFG_C_ROUNDS: crounds_d = cfg_i.data[3:0];
        shk_pkg::CFG_D_ROUNDS: frounds_d = cfg_i.data[3:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (ctrl_i.en) begin
      case (ctrl_i.op)
        shk_pkg::OP_LOAD: begin
          word_d = message_word_i;
          cnt_d  = (byte_count_i > shk_pkg::ByteCntFull) ? shk_pkg::ByteCntFull
                                                         : byte_count_i;
          last_d = last_word_i;
          if (!in_msg_q) begin
            lanes_d.a = key_lo_q ^ shk_pkg::InitA;
            lanes_d.b = key_hi_q ^ shk_pkg::InitB;
            lanes_d.c = key_lo_q ^ shk_pkg::InitC;
            lanes_d.d = key_hi_q ^ shk_pkg::InitD;
            len_d     = 8'h00;
            in_msg_d  = 1'b1;
          end
        end
        shk_pkg::OP_ABSORB: begin
          if (full) begin
            len_d = len_q + 8'd8;
            cnt_d = 4'd0;
            fin_d = 1'b0;
          end else begin
            len_d = len_fin;
            fin_d = 1'b1;
          end
          blk_d     = absorb_blk;
          lanes_d.d = lanes_q.d ^ absorb_blk;
          rcnt_d    = crounds_q;
        end
        shk_pkg::OP_ROUND: begin
          if (rcnt_q != 4'd0) begin
            lanes_d = lanes_rnd;
            rcnt_d  = rcnt_q - 4'd1;
          end
        end
        shk_pkg::OP_XOR_A: lanes_d.a = lanes_q.a ^ blk_q;
        shk_pkg::OP_FINAL: begin
          lanes_d.c = lanes_q.c ^ shk_pkg::FinalMark;
          rcnt_d    = frounds_q;
        end
        shk_pkg::OP_EMIT: begin
          hash_d      = lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;
          out_valid_d = 1'b1;
          in_msg_d    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q    <= '0;
      key_hi_q    <= '0;
      crounds_q   <= shk_pkg::CRoundsReset;
      frounds_q   <= shk_pkg::DRoundsReset;
      in_msg_q    <= 1'b0;
      len_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      fin_q       <= 1'b0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      key_lo_q    <= key_lo_d;
      key_hi_q    <= key_hi_d;
      crounds_q   <= crounds_d;
      frounds_q   <= frounds_d;
      in_msg_q    <= in_msg_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      fin_q       <= fin_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    word_q  <= word_d;
    blk_q   <= blk_d;
    hash_q  <= hash_d;
  end

  assign stat_o.last      = last_q;
  assign stat_o.fin       = fin_q;
  assign stat_o.rcnt_more = (rcnt_q > 4'd1);
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

// ===== hdl/shk_sequencer.sv =====
// ----------------------------------------------------------------------------
// shk_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module shk_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  shk_pkg::stat_t stat_i,
  output shk_pkg::ctrl_t ctrl_o
);

  logic [shk_pkg::PcW-1:0] pc_q, pc_d;
  shk_pkg::uword_t         uw;
  logic                    take;

  assign uw = shk_pkg::ucode_rom(pc_q);

  always_comb begin
    case (uw.cond)
      shk_pkg::C_NEVER:     take = 1'b0;
      shk_pkg::C_NO_ACCEPT: take = !in_valid_i;
      shk_pkg::C_RCNT_MORE: take = stat_i.rcnt_more;
      shk_pkg::C_NOT_LAST:  take = !stat_i.last;
      shk_pkg::C_NOT_FIN:   take = !stat_i.fin;
      shk_pkg::C_OUT_BUSY:  take = stat_i.out_busy;
      default:              take = 1'b0;
    endcase
    pc_d = take ? uw.target : uw.next;
  end

  always_comb begin
    ctrl_o.op = uw.op;
    case (uw.op)
      shk_pkg::OP_LOAD: ctrl_o.en = in_valid_i;
      shk_pkg::OP_EMIT: ctrl_o.en = !stat_i.out_busy;
      default:          ctrl_o.en = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= shk_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hdl/siphash_keyed_hash.sv =====
// ----------------------------------------------------------------------------
// siphash_keyed_hash
// Keyed SipHash-c-d engine over 64-bit little-endian message words.
//
//   channel  direction  handshake          word
//   in       input      in_valid / stall   message_word, byte_count, last_word
//   out      output     out_valid / stall  hash_value
//   cfg      input      cfg_valid / ready  cfg_index, cfg_data
//
// Each absorbed word runs c rounds and the final runs d rounds on the
// shared sip round unit, one round per cycle. A last word that holds eight
// bytes is followed by a separate length block.
// Reset clears step counter and message state, sets round counts to 2 and 4.
// The input stalls whenever the sequencer is off its wait step; a stalled
// output holds the emit step until the pending hash is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module siphash_keyed_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  shk_pkg::ctrl_t   ctrl;
  shk_pkg::stat_t   stat;
  shk_pkg::cfg_wr_t cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i && cfg_ready_o;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  assign in_stall_o = (ctrl.op != shk_pkg::OP_LOAD);

  shk_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  shk_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg),
    .message_word_i(message_word_i),
    .byte_count_i  (byte_count_i),
    .last_word_i   (last_word_i),
    .out_stall_i   (out_stall_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .hash_value_o  (hash_value_o)
  );

  `SHK_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `SHK_ASSERT_IMPL(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_o), $past(ctrl.op == shk_pkg::OP_EMIT))
  `SHK_ASSERT_NEXT(a_emit_waits, clk_i, rst_ni, ctrl.op == shk_pkg::OP_EMIT && out_valid_o && out_stall_i, ctrl.op == shk_pkg::OP_EMIT && out_valid_o)

endmodule
